FILE: rtl/core/lfs_pkg.sv
package lfs_pkg;

    localparam int unsigned CFG_ADDR_W   = 5;
    localparam int unsigned TENTHS_W     = 14;
    localparam int unsigned PULSE_W      = 11;
    localparam logic [5:0]  SAT6         = 6'd63;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX = 14'd9999;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_PERSIST_LIMIT   = 3'd0,
        REG_LOST_LIMIT      = 3'd1,
        REG_SNAP_LENGTH     = 3'd2,
        REG_BAR_LIMIT       = 3'd3,
        REG_TICKS_PER_TENTH = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        STEER_FREE    = 3'd0,
        STEER_PIVOT_R = 3'd1,
        STEER_PIVOT_L = 3'd2,
        STEER_SNAP_L  = 3'd3,
        STEER_SNAP_R  = 3'd4
    } steer_t;

    typedef enum logic [2:0] {
        DRV_STOP    = 3'd0,
        DRV_FWD     = 3'd1,
        DRV_TURN_L  = 3'd2,
        DRV_TURN_R  = 3'd3,
        DRV_PIVOT_L = 3'd4,
        DRV_PIVOT_R = 3'd5
    } drive_t;

    typedef struct packed {
        logic [5:0] persist_limit;
        logic [5:0] lost_limit;
        logic [5:0] snap_length;
        logic [1:0] bar_limit;
        logic [7:0] ticks_per_tenth;
    } cfg_t;

    typedef struct packed {
        logic [TENTHS_W-1:0] elapsed_tenths;
        logic                scan_req;
        logic                parking_flag;
        logic                running_flag;
        logic [PULSE_W-1:0]  right_pulse_us;
        logic [PULSE_W-1:0]  left_pulse_us;
        logic [2:0]          drive_code;
    } result_t;

    function automatic logic [PULSE_W-1:0] left_pulse(input logic [2:0] d);
        logic [PULSE_W-1:0] p;
        case (d)
            DRV_FWD:     p = 11'd1570;
            DRV_TURN_L:  p = 11'd1520;
            DRV_TURN_R:  p = 11'd1580;
            DRV_PIVOT_R: p = 11'd1560;
            default:     p = 11'd1500;
        endcase
        return p;
    endfunction

    function automatic logic [PULSE_W-1:0] right_pulse(input logic [2:0] d);
        logic [PULSE_W-1:0] p;
        case (d)
            DRV_FWD:     p = 11'd1418;
            DRV_TURN_L:  p = 11'd1410;
            DRV_TURN_R:  p = 11'd1480;
            DRV_PIVOT_L: p = 11'd1440;
            default:     p = 11'd1500;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/lfs_cfg.sv
module lfs_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lfs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output lfs_pkg::cfg_t                    cfg
);

    lfs_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.persist_limit   <= 6'd6;
            cfg_reg.lost_limit      <= 6'd40;
            cfg_reg.snap_length     <= 6'd40;
            cfg_reg.bar_limit       <= 2'd3;
            cfg_reg.ticks_per_tenth <= 8'd200;
        end
        else if (wr_en)
        begin
            unique case (idx)
                lfs_pkg::REG_PERSIST_LIMIT:   cfg_reg.persist_limit   <= pwdata[5:0];
                lfs_pkg::REG_LOST_LIMIT:      cfg_reg.lost_limit      <= pwdata[5:0];
                lfs_pkg::REG_SNAP_LENGTH:     cfg_reg.snap_length     <= pwdata[5:0];
                lfs_pkg::REG_BAR_LIMIT:       cfg_reg.bar_limit       <= pwdata[1:0];
                lfs_pkg::REG_TICKS_PER_TENTH: cfg_reg.ticks_per_tenth <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lfs_pkg::REG_PERSIST_LIMIT:   prdata = {26'd0, cfg_reg.persist_limit};
            lfs_pkg::REG_LOST_LIMIT:      prdata = {26'd0, cfg_reg.lost_limit};
            lfs_pkg::REG_SNAP_LENGTH:     prdata = {26'd0, cfg_reg.snap_length};
            lfs_pkg::REG_BAR_LIMIT:       prdata = {30'd0, cfg_reg.bar_limit};
            lfs_pkg::REG_TICKS_PER_TENTH: prdata = {24'd0, cfg_reg.ticks_per_tenth};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/lfs_core.sv
module lfs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              kind,
    input  logic [3:0]        sensor_bits,
    input  lfs_pkg::cfg_t     cfg,
    output lfs_pkg::result_t  result
);

    logic                 active_reg, active_next;
    logic                 parking_reg, parking_next;
    lfs_pkg::steer_t      steer_reg, steer_next;
    logic [1:0]           bar_count_reg, bar_count_next;
    logic                 on_bar_reg, on_bar_next;
    logic [5:0]           lost_reg, lost_next;
    logic [5:0]           rpersist_reg, rpersist_next;
    logic [5:0]           lpersist_reg, lpersist_next;
    logic [5:0]           snap_reg, snap_next;
    logic [7:0]           tick_div_reg, tick_div_next;
    logic [lfs_pkg::TENTHS_W-1:0] tenths_reg, tenths_next;
    lfs_pkg::drive_t      drive_reg, drive_next;
    logic                 scan;

    logic [3:0]           pat;
    logic [8:0]           div_inc;
    logic [1:0]           bar_inc;
    logic [5:0]           lost_inc;
    logic                 centered, near_center, veer_right, veer_left;

    assign pat          = ~sensor_bits;
    assign div_inc      = {1'b0, tick_div_reg} + 9'd1;
    assign bar_inc      = (bar_count_reg == 2'd3) ? 2'd3 : bar_count_reg + 2'd1;
    assign lost_inc     = (lost_reg == lfs_pkg::SAT6) ? lfs_pkg::SAT6 : lost_reg + 6'd1;
    assign centered     = (pat == 4'h6);
    assign near_center  = centered || (pat == 4'h4) || (pat == 4'h2);
    assign veer_right   = (pat == 4'hC) || (pat == 4'h1);
    assign veer_left    = (pat == 4'h3) || (pat == 4'h8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            parking_reg   <= 1'b0;
            steer_reg     <= lfs_pkg::STEER_FREE;
            bar_count_reg <= 2'd0;
            on_bar_reg    <= 1'b0;
            lost_reg      <= 6'd0;
            rpersist_reg  <= 6'd0;
            lpersist_reg  <= 6'd0;
            snap_reg      <= 6'd0;
            tick_div_reg  <= 8'd0;
            tenths_reg    <= '0;
            drive_reg     <= lfs_pkg::DRV_STOP;
        end
        else if (step)
        begin
            active_reg    <= active_next;
            parking_reg   <= parking_next;
            steer_reg     <= steer_next;
            bar_count_reg <= bar_count_next;
            on_bar_reg    <= on_bar_next;
            lost_reg      <= lost_next;
            rpersist_reg  <= rpersist_next;
            lpersist_reg  <= lpersist_next;
            snap_reg      <= snap_next;
            tick_div_reg  <= tick_div_next;
            tenths_reg    <= tenths_next;
            drive_reg     <= drive_next;
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        parking_next   = parking_reg;
        steer_next     = steer_reg;
        bar_count_next = bar_count_reg;
        on_bar_next    = on_bar_reg;
        lost_next      = lost_reg;
        rpersist_next  = rpersist_reg;
        lpersist_next  = lpersist_reg;
        snap_next      = snap_reg;
        tick_div_next  = tick_div_reg;
        tenths_next    = tenths_reg;
        drive_next     = drive_reg;
        scan           = 1'b0;

        if (kind)
        begin
            // start/stop button
            if (active_reg)
            begin
                active_next = 1'b0;
                drive_next  = lfs_pkg::DRV_STOP;
            end
            else
            begin
                bar_count_next = 2'd0;
                on_bar_next    = 1'b0;
                lost_next      = 6'd0;
                steer_next     = lfs_pkg::STEER_FREE;
                rpersist_next  = 6'd0;
                lpersist_next  = 6'd0;
                snap_next      = 6'd0;
                tenths_next    = '0;
                tick_div_next  = 8'd0;
                parking_next   = 1'b0;
                active_next    = 1'b1;
                drive_next     = lfs_pkg::DRV_FWD;
            end
        end
        else if (!active_reg)
        begin
            if (parking_reg && pat == 4'hF)
            begin
                drive_next   = lfs_pkg::DRV_STOP;
                parking_next = 1'b0;
            end
        end
        else
        begin
            // run timer
            if (div_inc >= {1'b0, cfg.ticks_per_tenth})
            begin
                tick_div_next = 8'd0;
                if (tenths_reg < lfs_pkg::TENTHS_MAX)
                    tenths_next = tenths_reg + 14'd1;
            end
            else
            begin
                tick_div_next = div_inc[7:0];
            end

            if (pat == 4'hF)
            begin
                if (!on_bar_reg)
                begin
                    on_bar_next    = 1'b1;
                    bar_count_next = bar_inc;
                end
                if (!on_bar_reg && bar_inc >= cfg.bar_limit)
                begin
                    active_next = 1'b0;
                    drive_next  = lfs_pkg::DRV_STOP;
                end
                else
                begin
                    steer_next    = lfs_pkg::STEER_FREE;
                    snap_next     = 6'd0;
                    rpersist_next = 6'd0;
                    lpersist_next = 6'd0;
                    drive_next    = lfs_pkg::DRV_FWD;
                    lost_next     = 6'd0;
                end
            end
            else
            begin
                on_bar_next   = 1'b0;
                rpersist_next = (pat != 4'hE) ? 6'd0 :
                                (rpersist_reg == lfs_pkg::SAT6) ? lfs_pkg::SAT6 :
                                rpersist_reg + 6'd1;
                lpersist_next = (pat != 4'h7) ? 6'd0 :
                                (lpersist_reg == lfs_pkg::SAT6) ? lfs_pkg::SAT6 :
                                lpersist_reg + 6'd1;

                unique case (steer_reg) inside
                    lfs_pkg::STEER_PIVOT_R, lfs_pkg::STEER_PIVOT_L:
                    begin
                        lost_next = 6'd0;
                        if (centered)
                        begin
                            snap_next = cfg.snap_length;
                            if (steer_reg == lfs_pkg::STEER_PIVOT_R)
                            begin
                                steer_next = lfs_pkg::STEER_SNAP_L;
                                drive_next = lfs_pkg::DRV_PIVOT_L;
                            end
                            else
                            begin
                                steer_next = lfs_pkg::STEER_SNAP_R;
                                drive_next = lfs_pkg::DRV_PIVOT_R;
                            end
                        end
                        else
                        begin
                            drive_next = (steer_reg == lfs_pkg::STEER_PIVOT_R) ?
                                         lfs_pkg::DRV_PIVOT_R : lfs_pkg::DRV_PIVOT_L;
                        end
                    end
                    lfs_pkg::STEER_SNAP_L, lfs_pkg::STEER_SNAP_R:
                    begin
                        lost_next = 6'd0;
                        if (snap_reg != 6'd0)
                        begin
                            snap_next  = snap_reg - 6'd1;
                            drive_next = (steer_reg == lfs_pkg::STEER_SNAP_L) ?
                                         lfs_pkg::DRV_PIVOT_L : lfs_pkg::DRV_PIVOT_R;
                        end
                        else
                        begin
                            steer_next = lfs_pkg::STEER_FREE;
                            drive_next = lfs_pkg::DRV_FWD;
                        end
                    end
                    default:
                    begin
                        // free following
                        if (rpersist_next >= cfg.persist_limit)
                        begin
                            steer_next    = lfs_pkg::STEER_PIVOT_R;
                            drive_next    = lfs_pkg::DRV_PIVOT_R;
                            rpersist_next = 6'd0;
                            lost_next     = 6'd0;
                        end
                        else if (lpersist_next >= cfg.persist_limit)
                        begin
                            steer_next    = lfs_pkg::STEER_PIVOT_L;
                            drive_next    = lfs_pkg::DRV_PIVOT_L;
                            lpersist_next = 6'd0;
                            lost_next     = 6'd0;
                        end
                        else if (near_center)
                        begin
                            drive_next = lfs_pkg::DRV_FWD;
                            lost_next  = 6'd0;
                        end
                        else if (veer_right)
                        begin
                            drive_next = lfs_pkg::DRV_TURN_R;
                            lost_next  = 6'd0;
                        end
                        else if (veer_left)
                        begin
                            drive_next = lfs_pkg::DRV_TURN_L;
                            lost_next  = 6'd0;
                        end
                        else if (lost_inc >= cfg.lost_limit)
                        begin
                            // line lost: stop, wait for parking, ask for a scan
                            lost_next    = cfg.lost_limit;
                            drive_next   = lfs_pkg::DRV_STOP;
                            active_next  = 1'b0;
                            parking_next = 1'b1;
                            scan         = 1'b1;
                        end
                        else
                        begin
                            lost_next = lost_inc;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.drive_code     = drive_next;
        result.left_pulse_us  = lfs_pkg::left_pulse(drive_next);
        result.right_pulse_us = lfs_pkg::right_pulse(drive_next);
        result.running_flag   = active_next;
        result.parking_flag   = parking_next;
        result.scan_req       = scan;
        result.elapsed_tenths = tenths_next;
    end

`ifndef SYNTHESIS
    a_steer_code: assert property (@(posedge clk) disable iff (!rst_n)
        steer_reg == lfs_pkg::STEER_FREE || steer_reg == lfs_pkg::STEER_PIVOT_R ||
        steer_reg == lfs_pkg::STEER_PIVOT_L || steer_reg == lfs_pkg::STEER_SNAP_L ||
        steer_reg == lfs_pkg::STEER_SNAP_R)
        else $error("steer state left its legal codes");

    a_idle_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> drive_reg == lfs_pkg::DRV_STOP)
        else $error("drive command not stop while idle");

    a_scan_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (step && scan) |=> (!active_reg && parking_reg))
        else $error("scan request without entering parking");

    a_tenths_sat: assert property (@(posedge clk) disable iff (!rst_n)
        tenths_reg <= lfs_pkg::TENTHS_MAX)
        else $error("run timer passed its limit");
`endif

endmodule

FILE: rtl/core/line_follow_steering_fsm.sv
// Line-follow steering controller. Each s_ transaction is a 0.5 ms tick
// (s_tuser = 0, s_tdata[3:0] = active-low sensors) or a start/stop button
// press (s_tuser = 1); each yields exactly one m_ transaction with the drive
// command, both servo pulse widths, status flags and the run timer. One
// transaction is accepted per cycle while s_tready is high; its result
// appears on the m_ side in the next cycle, set by the single register
// stage that holds the steering state and the result register. s_tready
// drops only while a result waits unread. Registers on the APB port: 0x00
// persist_limit, 0x04 lost_limit, 0x08 snap_length, 0x0C bar_limit,
// 0x10 ticks_per_tenth; write them only while no transaction is in flight.
module line_follow_steering_fsm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [3:0] sensor_bits
    input  logic                            s_tuser,   // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] drive_code, [13:3] left_pulse_us, [24:14] right_pulse_us,
    // [25] running_flag, [26] parking_flag, [27] scan_req,
    // [41:28] elapsed_tenths
    output logic [47:0]                     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lfs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    lfs_pkg::cfg_t    cfg;
    lfs_pkg::result_t result;
    lfs_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             step;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

    lfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .kind        (s_tuser),
        .sensor_bits (s_tdata[3:0]),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

endmodule
